/* hdl/hcbd_pkg.sv */
// Shared types, constants and helpers for the chunked body decoder.
// No dependencies; imported by http_chunked_body_decoder and hcbd_step.
`timescale 1ns / 1ps

package hcbd_pkg;

   localparam int LEN_BITS = 32;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

   typedef enum logic [3:0] {
      PH_SIZE  = 4'b0001,
      PH_DATA  = 4'b0010,
      PH_TRAIL = 4'b0100,
      PH_DONE  = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      DS_LEAD   = 3'b001,
      DS_DIGITS = 3'b010,
      DS_REST   = 3'b100
   } scan_type;

   typedef struct packed {
      phase_type           phase;
      scan_type            scan;
      logic [LEN_BITS-1:0] count;
   } parse_state_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] out_byte;
      logic       payload_valid;
      logic       body_done;
   } parse_result_type;

   localparam parse_state_type STATE_START = '{phase: PH_SIZE, scan: DS_LEAD, count: '0};

   // hex digit check and value; bit 4 (is_hex) is 0 for anything that is not a hex digit
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

/* hdl/http_chunked_body_decoder.sv */
// Top level of the chunked HTTP body decoder: parser state and result register.
// Depends on hcbd_pkg and hcbd_step.
//
//   channel | direction | handshake            | fields
//   req_    | in        | req_valid/req_stall  | in_byte[7:0], new_body
//   rsp_    | out       | rsp_valid/rsp_stall  | out_byte[7:0], payload_valid, body_done
//
// One byte per cycle while req_stall is low; results show the cycle after their byte.
// Parser state is updated on the accepting edge by a single-level decode.
// Synchronous active-high reset starts a size line with no result pending.
// req_stall is raised only while a held result is stalled on rsp_.
`timescale 1ns / 1ps

module http_chunked_body_decoder import hcbd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_new_body,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_payload_valid,
   output logic       rsp_body_done
);

   parse_state_type  state_ff, state_in;
   parse_result_type res;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       out_byte_ff;
   logic             payload_valid_ff, body_done_ff;
   logic             accept;

   hcbd_step u_step (
      .cur_state (state_ff),
      .in_byte   (req_in_byte),
      .new_body  (req_new_body),
      .nxt_state (state_in),
      .result    (res)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = res.valid;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res.valid) begin
         out_byte_ff      <= res.out_byte;
         payload_valid_ff <= res.payload_valid;
         body_done_ff     <= res.body_done;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_payload_valid = payload_valid_ff;
   assign rsp_body_done     = body_done_ff;

endmodule

/* hdl/hcbd_step.sv */
// Next-state and result logic for one body byte of the chunked decoder.
// Depends on hcbd_pkg.
`timescale 1ns / 1ps

module hcbd_step import hcbd_pkg::*; (
   input  parse_state_type  cur_state,
   input  logic [7:0]       in_byte,
   input  logic             new_body,
   output parse_state_type  nxt_state,
   output parse_result_type result
);

   parse_state_type st;
   logic [4:0]      hex;

   assign hex = hex_decode(in_byte);

   always_comb begin
      st        = new_body ? STATE_START : cur_state;
      nxt_state = st;
      result    = '0;

      unique case (st.phase)
         PH_SIZE: begin
            if (in_byte == CH_LF) begin
               nxt_state.scan = DS_LEAD;
               if (st.count == '0) begin
                  nxt_state.phase      = PH_DONE;
                  result.valid         = 1'b1;
                  result.body_done     = 1'b1;
               end else begin
                  nxt_state.phase = PH_DATA;
               end
            end else if (st.scan == DS_REST) begin
               nxt_state = st;
            end else if (st.scan == DS_LEAD &&
                         (in_byte == CH_SPACE || in_byte == CH_TAB || in_byte == CH_CR)) begin
               nxt_state = st;
            end else if (!hex[4]) begin
               nxt_state.scan = DS_REST;
            end else begin
               nxt_state.scan = DS_DIGITS;
               // saturate once the top nibble is occupied
               if (st.count[LEN_BITS-1 -: 4] != 4'd0) begin
                  nxt_state.count = LEN_MAX;
               end else begin
                  nxt_state.count = {st.count[LEN_BITS-5:0], hex[3:0]};
               end
            end
         end
         PH_DATA: begin
            result.valid         = 1'b1;
            result.out_byte      = in_byte;
            result.payload_valid = 1'b1;
            nxt_state.count      = st.count - LEN_BITS'(1);
            if (st.count == LEN_BITS'(1)) begin
               nxt_state.phase = PH_TRAIL;
            end
         end
         PH_TRAIL: begin
            if (in_byte == CH_LF) begin
               nxt_state = STATE_START;
            end
         end
         PH_DONE: begin
            nxt_state = st;
         end
         default: begin
            nxt_state = STATE_START;
         end
      endcase
   end

endmodule

/* hdl/hcbd_checker.sv */
// Port-level checks for the chunked body decoder, bound to the top level.
// Depends on http_chunked_body_decoder.
`timescale 1ns / 1ps

module hcbd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_payload_valid,
   input logic       rsp_body_done
);

   // held result must not move while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_payload_valid) && $stable(rsp_body_done))
      else $error("stalled result changed");

   // each item is either a payload byte or the done marker, never both
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload_valid != rsp_body_done))
      else $error("result kind not exclusive");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_body_done |-> rsp_out_byte == 8'd0)
      else $error("done marker carries data");

   // input side backs up exactly when the held result is stalled
   assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not track output stall");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_payload_valid (rsp_payload_valid),
   .rsp_body_done     (rsp_body_done)
);
